/* rtl/hotp_pkg.sv */
// ----------------------------------------------------------------------------
// hotp_pkg
// Shared constants and helpers for the HOTP code generator.
// ----------------------------------------------------------------------------
package hotp_pkg;

  localparam int KEY_REGS  = 8;
  localparam int KEY_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] IPAD_WORD = 32'h36363636;
  localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
  localparam logic [31:0] PAD_ONE   = 32'h80000000;
  localparam logic [31:0] LEN_INNER = 32'd576;
  localparam logic [31:0] LEN_OUTER = 32'd672;

  // block codes: which of the four message blocks is being compressed
  localparam logic [1:0] BLK_IKEY = 2'd0;
  localparam logic [1:0] BLK_IMSG = 2'd1;
  localparam logic [1:0] BLK_OKEY = 2'd2;
  localparam logic [1:0] BLK_OMSG = 2'd3;

  typedef struct packed {
    logic        start;
    logic [1:0]  blk;
  } hotp_cmd_t;

  typedef struct packed {
    logic        done;
    logic [159:0] digest;
  } hotp_sts_t;

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = K0;
    end else if (r < 7'd40) begin
      k = K1;
    end else if (r < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

/* rtl/hotp_sha1_core.sv */
// ----------------------------------------------------------------------------
// hotp_sha1_core
// One SHA-1 compression, one round per cycle. The 16-word message schedule
// lives in a small synchronous memory read in the cycle before the round.
// ----------------------------------------------------------------------------
module hotp_sha1_core import hotp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  hotp_cmd_t      cmd,
  input  logic [511:0]   blk_words,
  input  logic [159:0]   chain_in,
  output hotp_sts_t      sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [31:0]  wmem [16];
  logic [31:0]  rd_r;
  logic [1:0]   st_r, st_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic [4:0]   ld_r, ld_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [159:0] h_r;
  logic [159:0] dig_r;
  logic         done_r;
  logic [511:0] blk_r;

  logic         we;
  logic [3:0]   wa;
  logic [31:0]  wd;
  logic [3:0]   ra;
  logic [31:0]  w_cur;
  logic [31:0]  w_new;
  logic [31:0]  t;

  // schedule word for round r is the stored one (r<16) or the expansion
  // fed back from the stored ring; rd_r holds w[r-16] from the previous read
  // and the others come from a separate tap shift line.
  logic [31:0]  tap3, tap8, tap14;

  always_comb begin
    st_nxt  = st_r;
    rnd_nxt = rnd_r;
    ld_nxt  = ld_r;
    case (st_r)
      S_IDLE: begin
        if (cmd.start) begin
          st_nxt = S_LOAD;
          ld_nxt = 5'd0;
        end
      end
      S_LOAD: begin
        ld_nxt = ld_r + 5'd1;
        if (ld_r == 5'd15) begin
          st_nxt  = S_RUN;
          rnd_nxt = 7'd0;
          ld_nxt  = 5'd0;
        end
      end
      S_RUN: begin
        if (ld_r == 5'd0) begin
          ld_nxt = 5'd1;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
          if (rnd_r == 7'd79) begin
            st_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // read address leads the round: it names the word for the next round
  always_comb begin
    if (st_r == S_RUN && ld_r == 5'd0) begin
      ra = 4'd0;
    end else begin
      ra = rnd_r[3:0] + 4'd1;
    end
  end

  assign w_new = {tap3 ^ tap8 ^ tap14 ^ rd_r} << 1
               | {31'd0, tap3[31] ^ tap8[31] ^ tap14[31] ^ rd_r[31]};
  assign w_cur = (rnd_r < 7'd16) ? rd_r : w_new;
  assign t = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r
           + round_k(rnd_r) + w_cur;

  always_comb begin
    we = 1'b0;
    wa = ld_r[3:0];
    wd = blk_r[511 - 32*ld_r[3:0] -: 32];
    if (st_r == S_LOAD) begin
      we = 1'b1;
    end else if (st_r == S_RUN && ld_r != 5'd0 && rnd_r >= 7'd16) begin
      we = 1'b1;
      wa = rnd_r[3:0];
      wd = w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wmem[wa] <= wd;
    end
    rd_r <= wmem[ra];
  end

  // tap registers: hold w[r-3], w[r-8], w[r-14] as a short shift line of
  // the last 14 schedule words
  logic [31:0] line_r [14];
  always_ff @(posedge clk) begin
    if (st_r == S_RUN && ld_r != 5'd0) begin
      line_r[0] <= w_cur;
      for (int i = 1; i < 14; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end
  always_comb begin
    tap3  = line_r[2];
    tap8  = line_r[7];
    tap14 = line_r[13];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      rnd_r  <= 7'd0;
      ld_r   <= 5'd0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      rnd_r  <= rnd_nxt;
      ld_r   <= ld_nxt;
      done_r <= (st_r == S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && cmd.start) begin
      blk_r <= blk_words;
      h_r   <= chain_in;
      a_r   <= chain_in[159:128];
      b_r   <= chain_in[127:96];
      c_r   <= chain_in[95:64];
      d_r   <= chain_in[63:32];
      e_r   <= chain_in[31:0];
    end else if (st_r == S_RUN && ld_r != 5'd0) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (st_r == S_FIN) begin
      dig_r <= {h_r[159:128] + a_r, h_r[127:96] + b_r, h_r[95:64] + c_r,
                h_r[63:32] + d_r, h_r[31:0] + e_r};
    end
  end

  assign sts.done   = done_r;
  assign sts.digest = dig_r;

endmodule

/* rtl/hotp_code_generator_unit.sv */
// ----------------------------------------------------------------------------
// hotp_code_generator_unit
// HOTP (HMAC-SHA1 plus dynamic truncation) code generator.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each counter beat runs four SHA-1 compressions
// (inner key block, inner message block, outer key block, outer message
// block) on a single round engine at one round per cycle; each compression
// is started, loads the schedule memory, takes a read lead-in, runs its
// rounds, then does the chaining add and hands its digest off. Items are
// processed one at a time: the input stalls until the result beat has been
// handed off, so no new counter is taken while a code is in work or pending.
// Keys are written through the cfg port, which the user must do only while
// idle; the block itself does not enforce it. Keys reset to zero, and the
// 3-bit index reaches all eight key registers.
module hotp_code_generator_unit import hotp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          in_moving_counter,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [30:0]          out_truncated_code
);

  logic [KEY_W-1:0] key_r [KEY_REGS];
  logic             busy_r;
  logic [1:0]       blk_r;
  logic             kick_r;
  logic [63:0]      ctr_r;
  logic [159:0]     inner_r;
  logic [159:0]     chain;
  logic [511:0]     words;
  logic [511:0]     keyblk;
  logic [31:0]      pad;
  logic             ov_r;
  logic [30:0]      code_r;
  hotp_cmd_t        cmd;
  hotp_sts_t        sts;
  logic [159:0]     mac;
  logic [3:0]       off;
  logic [31:0]      word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_data;
    end
  end

  // key block: key XOR pad byte
  assign pad = (blk_r == BLK_IKEY) ? IPAD_WORD : OPAD_WORD;
  always_comb begin
    for (int i = 0; i < KEY_REGS; i++) begin
      keyblk[511 - 64*i -: 64] = key_r[i] ^ {pad, pad};
    end
  end

  always_comb begin
    case (blk_r)
      BLK_IKEY, BLK_OKEY: words = keyblk;
      BLK_IMSG: words = {ctr_r, PAD_ONE, 384'd0, LEN_INNER};
      BLK_OMSG: words = {inner_r, PAD_ONE, 288'd0, LEN_OUTER};
      default:  words = keyblk;
    endcase
  end

  // chain: init for key blocks, previous digest for message blocks
  assign chain = (blk_r == BLK_IKEY || blk_r == BLK_OKEY)
               ? {H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT} : sts.digest;

  assign cmd.start = kick_r;
  assign cmd.blk   = blk_r;

  hotp_sha1_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .blk_words (words),
    .chain_in  (chain),
    .sts       (sts)
  );

  // dynamic truncation on the final digest
  assign mac  = sts.digest;
  assign off  = mac[3:0];
  assign word = mac[159 - 8*off -: 32];

  assign in_stall = busy_r || ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      kick_r <= 1'b0;
      blk_r  <= BLK_IKEY;
      ov_r   <= 1'b0;
    end else begin
      kick_r <= 1'b0;
      if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
      if (in_valid && !in_stall) begin
        busy_r <= 1'b1;
        blk_r  <= BLK_IKEY;
        kick_r <= 1'b1;
      end else if (busy_r && sts.done) begin
        if (blk_r == BLK_OMSG) begin
          busy_r <= 1'b0;
          ov_r   <= 1'b1;
        end else begin
          blk_r  <= blk_r + 2'd1;
          kick_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ctr_r <= in_moving_counter;
    end
    if (busy_r && sts.done && blk_r == BLK_IMSG) begin
      inner_r <= sts.digest;
    end
    if (busy_r && sts.done && blk_r == BLK_OMSG) begin
      code_r <= word[30:0];
    end
  end

  assign out_valid          = ov_r;
  assign out_truncated_code = code_r;

`ifndef SYNTH
  // never work and hold a result at once
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(busy_r && ov_r))
    else $error("busy while result pending");
  // a finished outer block always raises the result beat
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && sts.done && blk_r == BLK_OMSG) |=> ov_r)
    else $error("result lost");
  // a start is issued only while busy
  a_kick: assert property (@(posedge clk) disable iff (!rst_n) kick_r |-> busy_r)
    else $error("start while idle");
`endif

endmodule

/* tb/hotp_code_generator_unit_tb.sv */
// ----------------------------------------------------------------------------
// hotp_code_generator_unit_tb
// Self-checking bench for the HOTP code generator. A small directed table
// (zero key extremes, RFC 4226 test vectors) is followed by random counters
// under a series of keys. Each code, known from the table or predicted by an
// HMAC-SHA1 model in the bench, is compared in order with the output beats.
// ----------------------------------------------------------------------------
module hotp_code_generator_unit_tb;
  import hotp_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RANDOM_ITEMS   = 1130;
  localparam int KEY_PHASES     = 6;

  typedef struct {
    logic        rfc_key;    // use the RFC 4226 test key for this row
    logic [63:0] counter;
    logic        typed;      // code below is known, else predict it
    logic [30:0] code;
  } hotp_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [63:0]          in_moving_counter = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [30:0]          out_truncated_code;

  logic [63:0] key_q [KEY_REGS];   // bench copy of the key registers
  logic [30:0] code_q [$];         // codes still owed by the block
  int          mismatches = 0;
  int          codes_seen = 0;
  int          counters_sent = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          bursts_on = 1'b1;

  hotp_row_t directed_rows [16];

  hotp_code_generator_unit dut (.*);

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: one SHA-1 compression, then HMAC and dynamic truncation.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [159:0] sha1_block(logic [159:0] h, logic [511:0] m);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) w[r] = m[511 - 32*r -: 32];
    for (int r = 16; r < 80; r++) w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    {a, b, c, d, e} = h;
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol32(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  function automatic logic [30:0] hotp_code(logic [63:0] counter);
    logic [511:0] key_blk;
    logic [159:0] iv, inner, mac;
    logic [3:0]   offset;
    logic [31:0]  word;
    iv = {H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
    for (int i = 0; i < KEY_REGS; i++) key_blk[511 - 64*i -: 64] = key_q[i];
    inner = sha1_block(iv, key_blk ^ {16{IPAD_WORD}});
    inner = sha1_block(inner, {counter, PAD_ONE, 384'd0, LEN_INNER});
    mac   = sha1_block(iv, key_blk ^ {16{OPAD_WORD}});
    mac   = sha1_block(mac, {inner, PAD_ONE, 288'd0, LEN_OUTER});
    // low nibble of the last byte picks the four-byte window
    offset = mac[3:0];
    word   = mac[159 - 8*offset -: 32];
    return word[30:0];
  endfunction

  // --------------------------------------------------------------------------
  // Config and input side.
  // --------------------------------------------------------------------------
  task automatic wait_drained();
    while (code_q.size() != 0) @(posedge clk);
  endtask

  // Load all eight key registers; call only with the block drained.
  task automatic load_key(logic [63:0] next_key [KEY_REGS]);
    for (int i = 0; i < KEY_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= next_key[i];
      key_q[i]  = next_key[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Present one counter beat and hold it until taken.
  task automatic send_counter(logic [63:0] counter, bit typed, logic [30:0] code);
    in_valid          <= 1'b1;
    in_moving_counter <= counter;
    do @(posedge clk); while (in_stall);
    code_q.push_back(typed ? code : hotp_code(counter));
    counters_sent++;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_counter();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 255));           // small counters
      1: return ~64'($urandom_range(0, 255));          // near all-ones
      2: return 64'(1) << $urandom_range(0, 63);       // single bit
      3: return ~(64'(1) << $urandom_range(0, 63));    // single hole
      default: return rand64();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check beats, drive stall bursts, watch for hangs.
  // --------------------------------------------------------------------------
  task automatic report(string what, logic [30:0] got, logic [30:0] want);
    mismatches++;
    $display("ERROR %0t: %s got %08h expected %08h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        codes_seen++;
        if (code_q.size() == 0) begin
          report("truncated_code with nothing owed", out_truncated_code, '0);
        end else begin
          if (out_truncated_code !== code_q[0]) begin
            report("truncated_code", out_truncated_code, code_q[0]);
          end
          void'(code_q.pop_front());
        end
      end
      // stall in short bursts, none once bursts are switched off
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 2);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      // count cycles with no beat moving on either channel
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] key_set [KEY_REGS];
    logic [63:0] rfc_key [KEY_REGS];
    logic        on_rfc;
    int          per_phase;

    // ASCII "12345678901234567890", zero padded to 64 bytes
    rfc_key = '{64'h3132333435363738, 64'h3930313233343536, 64'h3738393000000000,
                64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
    // zero key rows first (reset value), then RFC 4226 appendix D vectors
    directed_rows = '{
      '{1'b0, 64'h0,                1'b0, 31'h0},
      '{1'b0, 64'hffffffffffffffff, 1'b0, 31'h0},
      '{1'b0, 64'haaaaaaaaaaaaaaaa, 1'b0, 31'h0},
      '{1'b0, 64'h5555555555555555, 1'b0, 31'h0},
      '{1'b0, 64'h8000000000000000, 1'b0, 31'h0},
      '{1'b0, 64'h1,                1'b0, 31'h0},
      '{1'b1, 64'd0, 1'b1, 31'h4c93cf18},
      '{1'b1, 64'd1, 1'b1, 31'h41397eea},
      '{1'b1, 64'd2, 1'b1, 31'h082fef30},
      '{1'b1, 64'd3, 1'b1, 31'h66ef7655},
      '{1'b1, 64'd4, 1'b1, 31'h61c5938a},
      '{1'b1, 64'd5, 1'b1, 31'h33c083d4},
      '{1'b1, 64'd6, 1'b1, 31'h7256c032},
      '{1'b1, 64'd7, 1'b1, 31'h04e5b397},
      '{1'b1, 64'd8, 1'b1, 31'h2823443f},
      '{1'b1, 64'd9, 1'b1, 31'h2679dc69}
    };

    for (int i = 0; i < KEY_REGS; i++) key_q[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: switch to the test key when the rows ask for it
    on_rfc = 1'b0;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].rfc_key != on_rfc) begin
        in_valid <= 1'b0;
        wait_drained();
        load_key(rfc_key);
        on_rfc = 1'b1;
      end
      send_counter(directed_rows[r].counter, directed_rows[r].typed,
                   directed_rows[r].code);
    end

    // random counters under a run of keys: all ones, short, full random twice,
    // zero, full random; the last phase runs without bursts on either side
    per_phase = RANDOM_ITEMS / KEY_PHASES;
    for (int p = 0; p < KEY_PHASES; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      for (int i = 0; i < KEY_REGS; i++) begin
        case (p)
          0: key_set[i] = '1;
          1: key_set[i] = (i < 3) ? rand64() : 64'h0;
          4: key_set[i] = '0;
          default: key_set[i] = rand64();
        endcase
      end
      load_key(key_set);
      if (p == KEY_PHASES - 1) bursts_on = 1'b0;
      for (int n = 0; n < per_phase; n++) begin
        // hold off once, halfway through the third phase, until every code owed has come back
        if (n == per_phase / 2 && p == 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_counter(pick_counter(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (500) @(posedge clk);

    $display("Sent %0d counters under %0d keys, checked %0d codes, %0d mismatches.",
             counters_sent, KEY_PHASES + 2, codes_seen, mismatches);
    if (mismatches == 0 && code_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* hotp_code_generator_unit.f */
rtl/hotp_pkg.sv
rtl/hotp_sha1_core.sv
rtl/hotp_code_generator_unit.sv
tb/hotp_code_generator_unit_tb.sv
